// File: hw/rtl/hsw_pkg.sv
package hsw_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_HEADER_BYTES  = 3'd0;
    localparam logic [2:0] REG_HEADER_LENGTH = 3'd1;
    localparam logic [2:0] REG_WORD_COUNT    = 3'd2;
    localparam logic [2:0] REG_WORD_SIZE     = 3'd3;
    localparam logic [2:0] REG_BIG_ENDIAN    = 3'd4;

    // word size codes, anything above WS_16 means 32-bit words
    localparam logic [1:0] WS_8  = 2'd0;
    localparam logic [1:0] WS_16 = 2'd1;
    localparam logic [1:0] WS_32 = 2'd2;

    typedef struct packed {
        logic [31:0] data_word;
        logic        status;
        logic        last_word;
    } t_result;

endpackage

// File: hw/rtl/hsw_out_skid.sv
module hsw_out_skid
    import hsw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_stall
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    take;

    assign take = r_out_valid && !i_stall;

    // push only arrives while the skid stage is empty
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = i_push;
                n_skid       = i_data;
            end else begin
                n_out_valid = i_push;
                n_out       = i_data;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// File: hw/rtl/header_sync_word_extractor.sv
// output: a result is registered in the output register, or in the skid stage while i_out_stall holds the output
// throughput: one byte per cycle while o_in_stall is low; the hunt/collect state updates in a single pass per byte,
//   and the output register plus a skid stage keep input flowing while a result waits
// reset (i_rst_n low, synchronous): all registers but the output data payloads return to defaults, the block
//   hunts for the header with a full search budget and the output side holds no result
module header_sync_word_extractor
    import hsw_pkg::*;
#(
    parameter int SEARCH_BUDGET  = 256,
    parameter int MAX_HEADER_LEN = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_data_word,
    output logic        o_status,
    output logic        o_last_word
);

    localparam int HUNT_W  = $clog2(SEARCH_BUDGET + 1);
    localparam int HDR_CAP = (MAX_HEADER_LEN < 4) ? MAX_HEADER_LEN : 4;
    localparam logic [HUNT_W-1:0] BUDGET = HUNT_W'(SEARCH_BUDGET);

    // configuration registers
    logic [31:0] r_header_bytes;
    logic [2:0]  r_header_length;
    logic [7:0]  r_word_count;
    logic [1:0]  r_word_size;
    logic        r_big_endian;

    // parser state
    logic              r_collecting, n_collecting;
    logic [1:0]        r_header_pos, n_header_pos;
    logic [HUNT_W-1:0] r_hunt_left, n_hunt_left;
    logic [1:0]        r_byte_pos, n_byte_pos;
    logic [31:0]       r_word_accum, n_word_accum;
    logic [7:0]        r_words_left, n_words_left;

    logic        accept;
    logic        full;
    logic        push;
    t_result     res;
    t_result     out_data;

    logic [2:0]        eff_len;
    logic [2:0]        pos_inc;
    logic [7:0]        want;
    logic [HUNT_W-1:0] hunt_dec;
    logic [2:0]        nb;
    logic [31:0]       accum_new;
    logic [31:0]       word_mask;
    logic [7:0]        words_dec;

    // configuration writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_bytes  <= '0;
            r_header_length <= 3'd1;
            r_word_count    <= 8'd1;
            r_word_size     <= WS_8;
            r_big_endian    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HEADER_BYTES:  r_header_bytes  <= i_cfg_data;
                REG_HEADER_LENGTH: r_header_length <= i_cfg_data[2:0];
                REG_WORD_COUNT:    r_word_count    <= i_cfg_data[7:0];
                REG_WORD_SIZE:     r_word_size     <= i_cfg_data[1:0];
                REG_BIG_ENDIAN:    r_big_endian    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // take a byte whenever the skid stage has room
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    // effective header length: zero acts as one, saturate at the cap
    always_comb begin
        eff_len = r_header_length;
        if (eff_len == 3'd0) begin
            eff_len = 3'd1;
        end
        if (eff_len > 3'(HDR_CAP)) begin
            eff_len = 3'(HDR_CAP);
        end
    end

    // word size in bytes and the emit mask; code three acts as 32 bits
    always_comb begin
        case (r_word_size)
            WS_8: begin
                nb        = 3'd1;
                word_mask = 32'h0000_00ff;
            end
            WS_16: begin
                nb        = 3'd2;
                word_mask = 32'h0000_ffff;
            end
            default: begin
                nb        = 3'd4;
                word_mask = 32'hffff_ffff;
            end
        endcase
    end

    assign want      = r_header_bytes[{r_header_pos, 3'b000} +: 8];
    assign pos_inc   = {1'b0, r_header_pos} + 3'd1;
    assign hunt_dec  = (r_hunt_left != '0) ? r_hunt_left - 1'b1 : r_hunt_left;
    assign words_dec = (r_words_left != 8'd0) ? r_words_left - 8'd1 : r_words_left;
    assign accum_new = r_big_endian ? {r_word_accum[23:0], i_rx_byte}
                                    : r_word_accum | ({24'd0, i_rx_byte} << {r_byte_pos, 3'b000});

    always_comb begin
        n_collecting = r_collecting;
        n_header_pos = r_header_pos;
        n_hunt_left  = r_hunt_left;
        n_byte_pos   = r_byte_pos;
        n_word_accum = r_word_accum;
        n_words_left = r_words_left;
        push          = 1'b0;
        res.data_word = '0;
        res.status    = 1'b0;
        res.last_word = 1'b0;
        if (accept) begin
            if (!r_collecting) begin
                n_hunt_left = hunt_dec;
                if (i_rx_byte == want && pos_inc >= eff_len) begin
                    // header complete, wins over an exhausted budget
                    n_header_pos = 2'd0;
                    n_hunt_left  = BUDGET;
                    n_byte_pos   = 2'd0;
                    n_word_accum = '0;
                    n_words_left = r_word_count;
                    n_collecting = (r_word_count != 8'd0);
                end else begin
                    n_header_pos = (i_rx_byte == want) ? pos_inc[1:0] : 2'd0;
                    if (hunt_dec == '0) begin
                        // budget gone: report failure and hunt afresh
                        push         = 1'b1;
                        res.status   = 1'b1;
                        n_header_pos = 2'd0;
                        n_hunt_left  = BUDGET;
                        n_byte_pos   = 2'd0;
                        n_word_accum = '0;
                        n_words_left = 8'd0;
                    end
                end
            end else if ({1'b0, r_byte_pos} + 3'd1 < nb) begin
                n_byte_pos   = r_byte_pos + 2'd1;
                n_word_accum = accum_new;
            end else begin
                // word finished on this byte
                push          = 1'b1;
                res.data_word = accum_new & word_mask;
                n_byte_pos    = 2'd0;
                n_word_accum  = '0;
                n_words_left  = words_dec;
                if (words_dec == 8'd0) begin
                    res.last_word = 1'b1;
                    n_collecting  = 1'b0;
                    n_header_pos  = 2'd0;
                    n_hunt_left   = BUDGET;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_header_pos <= 2'd0;
            r_hunt_left  <= BUDGET;
            r_byte_pos   <= 2'd0;
            r_word_accum <= '0;
            r_words_left <= 8'd0;
        end else begin
            r_collecting <= n_collecting;
            r_header_pos <= n_header_pos;
            r_hunt_left  <= n_hunt_left;
            r_byte_pos   <= n_byte_pos;
            r_word_accum <= n_word_accum;
            r_words_left <= n_words_left;
        end
    end

    // output register with skid stage
    hsw_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .o_full  (full),
        .o_valid (o_out_valid),
        .o_data  (out_data),
        .i_stall (i_out_stall)
    );

    assign o_data_word = out_data.data_word;
    assign o_status    = out_data.status;
    assign o_last_word = out_data.last_word;

    // a held skid entry implies a result is already on the output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("skid stage holds a result with the output empty");

    // a frame in progress always has a word left to deliver
    a_words_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_collecting |-> r_words_left != 8'd0)
        else $error("collecting with no words left");

    // while hunting, no partial word is carried
    a_hunt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_collecting |-> (r_byte_pos == 2'd0 && r_word_accum == 32'd0))
        else $error("partial word left over while hunting");

    // a failure result only follows a byte taken while hunting
    a_fail_from_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && res.status) |-> (accept && !r_collecting))
        else $error("failure result outside the hunt");

endmodule
